/* rtl/tbtg_pkg.sv */
// ----------------------------------------------------------------------------
// Thought budget token gate package
// Shared types, register map, stop codes and window match helpers.
// ----------------------------------------------------------------------------
package tbtg_pkg;

	localparam int WindowDepth = 4;
	localparam int TokenBits   = 16;
	localparam int SlotBits    = 16;
	localparam int LenBits     = 3;
	localparam int CountBits   = 16;
	localparam int CfgBits     = 64;
	localparam int AddrBits    = 6;

	typedef logic [TokenBits-1:0]                  token_t;
	typedef logic [WindowDepth-1:0][TokenBits-1:0] window_t;
	typedef logic [LenBits-1:0]                    len_t;
	typedef logic [CountBits-1:0]                  count_t;
	typedef logic [CfgBits-1:0]                    cfg_word_t;

	localparam count_t DefaultTokenLimit = count_t'(64);
	localparam count_t CountMax          = '1;

	typedef enum logic [1:0] {
		STOP_RUN   = 2'd0,
		STOP_END   = 2'd1,
		STOP_LIMIT = 2'd2
	} stop_code_t;

	typedef enum logic [2:0] {
		REG_THOUGHT_BUDGET = 3'd0,
		REG_OPEN_LENGTH    = 3'd1,
		REG_OPEN_TOKENS    = 3'd2,
		REG_CLOSE_LENGTH   = 3'd3,
		REG_CLOSE_TOKENS   = 3'd4,
		REG_END_COUNT      = 3'd5,
		REG_END_TOKENS     = 3'd6,
		REG_TOKEN_LIMIT    = 3'd7
	} reg_idx_t;

	// Lengths above the window depth behave as the window depth.
	function automatic len_t clamp_len(len_t n);
		return (n > len_t'(WindowDepth)) ? len_t'(WindowDepth) : n;
	endfunction

	// One token slot out of a packed sequence register.
	function automatic token_t get_slot(cfg_word_t seq, logic [1:0] idx);
		return seq[idx*SlotBits +: TokenBits];
	endfunction

	// The len newest window entries, newest first, equal the sequence read backwards.
	function automatic logic tail_match(window_t win, len_t fill, cfg_word_t seq, len_t len);
		logic       ok;
		logic [1:0] idx;
		ok = (fill >= len);
		for (int k = 0; k < WindowDepth; k++) begin
			idx = 2'(len - len_t'(k) - len_t'(1));
			if ((len_t'(k) < len) && (win[k] != get_slot(seq, idx))) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

/* rtl/thought_budget_token_gate_core.sv */
// ----------------------------------------------------------------------------
// Thought budget token gate
// Decode loop token gate with thought tracking, forced close and stop logic.
// ----------------------------------------------------------------------------
// Each item is one step of a decode loop and yields exactly one result item.
// The block passes the sampled token through, or, while a forced close is in
// progress, emits the next token of the close sequence instead. When thought
// tracking is enabled (nonzero budget, open length and close length) it keeps
// the four newest tokens and matches their tail against the open and close
// sequences, counts tokens inside a thought and arms the forced close once the
// count reaches the budget. Generation stops on an end token or once
// token_limit tokens have been emitted; after that every item returns a
// stopped result with no token until reset. The block takes one item per
// clock while the result channel is not stalled: an item waits in the input
// register, where the whole step is computed against the state registers,
// and its result lands in the output register when the step retires.
// A stalled result holds the step in the input register and stalls the
// input channel. The recurrence through the state registers sets that rate.
// Registers are written through the APB port at byte address 8*i and may
// only be written while no item is in flight.
module thought_budget_token_gate_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sampled_token,
	// Result item channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_token,
	output logic        token_valid,
	output logic        was_forced,
	output logic        stopped,
	output logic [1:0]  stop_code,
	output logic        sample_next,
	output logic        in_thought_now,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [tbtg_pkg::AddrBits-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// Configuration registers.
	tbtg_pkg::count_t    thought_budget_q;
	tbtg_pkg::len_t      open_length_q;
	tbtg_pkg::cfg_word_t open_tokens_q;
	tbtg_pkg::len_t      close_length_q;
	tbtg_pkg::cfg_word_t close_tokens_q;
	tbtg_pkg::len_t      end_count_q;
	tbtg_pkg::cfg_word_t end_tokens_q;
	tbtg_pkg::count_t    token_limit_q;

	// Step state.
	tbtg_pkg::window_t    window_q;
	tbtg_pkg::len_t       fill_q;
	logic                 thought_q;
	tbtg_pkg::count_t     thought_cnt_q;
	logic                 force_q;
	tbtg_pkg::len_t       force_pos_q;
	tbtg_pkg::count_t     emitted_q;
	logic                 halt_q;
	tbtg_pkg::stop_code_t halt_code_q;

	// Input register stage.
	logic                valid_s1;
	tbtg_pkg::token_t    token_s1;

	// Next-state and result values of the step held in the input register.
	tbtg_pkg::window_t    window_n;
	tbtg_pkg::len_t       fill_n;
	logic                 thought_n;
	tbtg_pkg::count_t     thought_cnt_n;
	logic                 force_n;
	tbtg_pkg::len_t       force_pos_n;
	tbtg_pkg::count_t     emitted_n;
	logic                 halt_n;
	tbtg_pkg::stop_code_t halt_code_n;
	tbtg_pkg::token_t     tok;
	logic                 tok_valid;
	logic                 forced;
	logic                 end_hit;
	tbtg_pkg::len_t       olen;
	logic                 tracking;
	tbtg_pkg::len_t       clen;
	tbtg_pkg::len_t       elen;

	logic in_accept;
	logic advance;
	logic cfg_write;
	tbtg_pkg::reg_idx_t reg_idx;

	// ------------------------------------------------------------------------
	// Handshake. The step in the input register retires whenever the output
	// register is empty or being drained, so input and output overlap fully.
	// ------------------------------------------------------------------------
	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			token_s1 <= sampled_token;
		end
	end

	// ------------------------------------------------------------------------
	// Configuration port. Only paddr[5:3] selects a register.
	// ------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign reg_idx   = tbtg_pkg::reg_idx_t'(paddr[5:3]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thought_budget_q <= '0;
			open_length_q    <= '0;
			open_tokens_q    <= '0;
			close_length_q   <= '0;
			close_tokens_q   <= '0;
			end_count_q      <= '0;
			end_tokens_q     <= '0;
			token_limit_q    <= tbtg_pkg::DefaultTokenLimit;
		end else if (cfg_write) begin
			unique case (reg_idx)
				tbtg_pkg::REG_THOUGHT_BUDGET: thought_budget_q <= pwdata[15:0];
				tbtg_pkg::REG_OPEN_LENGTH:    open_length_q    <= pwdata[2:0];
				tbtg_pkg::REG_OPEN_TOKENS:    open_tokens_q    <= pwdata;
				tbtg_pkg::REG_CLOSE_LENGTH:   close_length_q   <= pwdata[2:0];
				tbtg_pkg::REG_CLOSE_TOKENS:   close_tokens_q   <= pwdata;
				tbtg_pkg::REG_END_COUNT:      end_count_q      <= pwdata[2:0];
				tbtg_pkg::REG_END_TOKENS:     end_tokens_q     <= pwdata;
				tbtg_pkg::REG_TOKEN_LIMIT:    token_limit_q    <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tbtg_pkg::REG_THOUGHT_BUDGET: prdata = 64'(thought_budget_q);
			tbtg_pkg::REG_OPEN_LENGTH:    prdata = 64'(open_length_q);
			tbtg_pkg::REG_OPEN_TOKENS:    prdata = open_tokens_q;
			tbtg_pkg::REG_CLOSE_LENGTH:   prdata = 64'(close_length_q);
			tbtg_pkg::REG_CLOSE_TOKENS:   prdata = close_tokens_q;
			tbtg_pkg::REG_END_COUNT:      prdata = 64'(end_count_q);
			tbtg_pkg::REG_END_TOKENS:     prdata = end_tokens_q;
			tbtg_pkg::REG_TOKEN_LIMIT:    prdata = 64'(token_limit_q);
		endcase
	end

	// ------------------------------------------------------------------------
	// One decode step. The limit check comes first, then the token choice
	// (forced close token or sampled token), then window and thought
	// tracking on the new token, and finally the end token and limit stops.
	// ------------------------------------------------------------------------
	always_comb begin
		olen     = tbtg_pkg::clamp_len(open_length_q);
		clen     = tbtg_pkg::clamp_len(close_length_q);
		elen     = tbtg_pkg::clamp_len(end_count_q);
		tracking = (thought_budget_q != '0) && (olen != '0) && (clen != '0);

		window_n      = window_q;
		fill_n        = fill_q;
		thought_n     = thought_q;
		thought_cnt_n = thought_cnt_q;
		force_n       = force_q;
		force_pos_n   = force_pos_q;
		emitted_n     = emitted_q;
		halt_n        = halt_q;
		halt_code_n   = halt_code_q;
		tok           = '0;
		tok_valid     = 1'b0;
		forced        = 1'b0;
		end_hit       = 1'b0;

		// The limit may already be met when the step starts, for example
		// after a lower limit was written.
		if (!halt_q && (emitted_q >= token_limit_q)) begin
			halt_n      = 1'b1;
			halt_code_n = tbtg_pkg::STOP_LIMIT;
		end

		if (!halt_n) begin
			// A close sequence that was shortened under a running force ends it.
			if (tracking && force_n && (force_pos_n >= clen)) begin
				force_n     = 1'b0;
				force_pos_n = '0;
			end
			if (tracking && force_n) begin
				tok         = tbtg_pkg::get_slot(close_tokens_q, force_pos_n[1:0]);
				force_pos_n = force_pos_n + tbtg_pkg::len_t'(1);
				if (force_pos_n >= clen) begin
					force_n     = 1'b0;
					force_pos_n = '0;
				end
				forced = 1'b1;
			end else begin
				tok = token_s1;
			end
			tok_valid = 1'b1;
			if (emitted_q != tbtg_pkg::CountMax) begin
				emitted_n = emitted_q + tbtg_pkg::count_t'(1);
			end

			if (tracking) begin
				window_n = {window_q[tbtg_pkg::WindowDepth-2:0], tok};
				if (fill_q < tbtg_pkg::len_t'(tbtg_pkg::WindowDepth)) begin
					fill_n = fill_q + tbtg_pkg::len_t'(1);
				end
				// An open match wins over a close match.
				if (tbtg_pkg::tail_match(window_n, fill_n, open_tokens_q, olen)) begin
					thought_n     = 1'b1;
					thought_cnt_n = '0;
				end else if (tbtg_pkg::tail_match(window_n, fill_n, close_tokens_q, clen)) begin
					thought_n = 1'b0;
				end else if (thought_n && (thought_cnt_n != tbtg_pkg::CountMax)) begin
					thought_cnt_n = thought_cnt_n + tbtg_pkg::count_t'(1);
				end
				if (thought_n && !force_n && (thought_cnt_n >= thought_budget_q)) begin
					force_n     = 1'b1;
					force_pos_n = '0;
				end
			end

			for (int k = 0; k < tbtg_pkg::WindowDepth; k++) begin
				if ((tbtg_pkg::len_t'(k) < elen) &&
				    (tbtg_pkg::get_slot(end_tokens_q, 2'(k)) == tok)) begin
					end_hit = 1'b1;
				end
			end
			if (end_hit) begin
				halt_n      = 1'b1;
				halt_code_n = tbtg_pkg::STOP_END;
			end else if (emitted_n >= token_limit_q) begin
				halt_n      = 1'b1;
				halt_code_n = tbtg_pkg::STOP_LIMIT;
			end
		end
	end

	// State commits when the step retires into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= '0;
			fill_q        <= '0;
			thought_q     <= 1'b0;
			thought_cnt_q <= '0;
			force_q       <= 1'b0;
			force_pos_q   <= '0;
			emitted_q     <= '0;
			halt_q        <= 1'b0;
			halt_code_q   <= tbtg_pkg::STOP_RUN;
		end else if (advance) begin
			window_q      <= window_n;
			fill_q        <= fill_n;
			thought_q     <= thought_n;
			thought_cnt_q <= thought_cnt_n;
			force_q       <= force_n;
			force_pos_q   <= force_pos_n;
			emitted_q     <= emitted_n;
			halt_q        <= halt_n;
			halt_code_q   <= halt_code_n;
		end
	end

	// ------------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_token      <= tok;
			token_valid    <= tok_valid;
			was_forced     <= forced;
			stopped        <= halt_n;
			stop_code      <= halt_n ? halt_code_n : tbtg_pkg::STOP_RUN;
			sample_next    <= !halt_n && !(tracking && force_n);
			in_thought_now <= thought_n;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// Once stopped, the block stays stopped until reset.
	assert property (@(posedge clk) disable iff (!arst_n) halt_q |=> halt_q)
		else $error("stop condition was left without reset");

	// A result without a token must be a stopped result that asks for no sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !token_valid) |-> (stopped && !sample_next))
		else $error("result without token is not a stopped result");

	// A forced token is always an emitted token.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_forced) |-> token_valid)
		else $error("forced result carries no token");

	// The input side only stalls while the output side holds a result back.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output could drain");

endmodule

/* bench/thought_budget_token_gate_core_tb.sv */
// ----------------------------------------------------------------------------
// Thought budget token gate testbench
// Drives decode steps through the token gate and checks every result item
// against a cycle-free model of the gate kept inside the bench.
// ----------------------------------------------------------------------------
// The bench runs a set of named tests in turn. The first tests are directed:
// they cover the reset defaults, a full forced close, open sequence priority,
// lengths above the window depth, and a close length that shrinks in the
// middle of a forced close. Random phases follow. Each phase programs a fresh
// register setting and then sends well-formed decode traffic: open and close
// sequences, short runs of tokens from a small alphabet so that partial
// matches happen, and some full-range noise. The last test ends generation,
// on an end token or on the token limit, and checks the stopped items after.
// Both handshakes idle at random, except for one phase that runs flat out.
module thought_budget_token_gate_core_tb;

	// Which way the final test stops generation.
	typedef enum int {
		HALT_BY_END_TOKEN,
		HALT_BY_LIMIT,
		HALT_BY_LOWERED_LIMIT
	} halt_path_t;

	// One result item as the gate is expected to produce it.
	typedef struct packed {
		tbtg_pkg::token_t     tok;
		logic                 valid;
		logic                 forced;
		logic                 halted;
		tbtg_pkg::stop_code_t code;
		logic                 sample_next;
		logic                 thinking;
	} gate_result_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	tbtg_pkg::token_t sampled_token;
	logic             out_valid;
	logic             out_stall;
	tbtg_pkg::token_t out_token;
	logic             token_valid;
	logic             was_forced;
	logic             stopped;
	logic [1:0]       stop_code;
	logic             sample_next;
	logic             in_thought_now;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [5:0]       paddr;
	logic [63:0]      pwdata;
	logic [63:0]      prdata;
	logic             pready;

	// Shadow copy of the configuration registers.
	tbtg_pkg::count_t    cfg_budget;
	tbtg_pkg::count_t    cfg_limit;
	tbtg_pkg::len_t      cfg_open_len;
	tbtg_pkg::len_t      cfg_close_len;
	tbtg_pkg::len_t      cfg_end_cnt;
	tbtg_pkg::cfg_word_t cfg_open_seq;
	tbtg_pkg::cfg_word_t cfg_close_seq;
	tbtg_pkg::cfg_word_t cfg_end_seq;

	// Gate state as the model tracks it. Entry 0 of the window is the newest.
	tbtg_pkg::token_t     recent [tbtg_pkg::WindowDepth];
	int                   recent_fill;
	logic                 thinking;
	int                   thought_cnt;
	logic                 forcing;
	int                   force_pos;
	int                   gate_emitted;
	logic                 halted;
	tbtg_pkg::stop_code_t halt_reason;

	gate_result_t pending_results [$];
	gate_result_t want;
	int           mismatch_count = 0;
	int           result_index = 0;
	logic         no_gaps;

	thought_budget_token_gate_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sampled_token  (sampled_token),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_token      (out_token),
		.token_valid    (token_valid),
		.was_forced     (was_forced),
		.stopped        (stopped),
		.stop_code      (stop_code),
		.sample_next    (sample_next),
		.in_thought_now (in_thought_now),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the gate hangs a handshake.
	initial begin
		#500000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		mismatch_count++;
		$display("mismatch at result %0d, %s: got %0h, expected %0h",
			result_index, what, got, exp_val);
	endtask

	// About 23 rolls in a hundred come out idle, unless the current phase runs flat out.
	function automatic logic gap_roll();
		return !no_gaps && ($urandom_range(0, 99) < 23);
	endfunction

	// Sequence and end slot counts above the window depth act as the window depth.
	function automatic int eff_len(tbtg_pkg::len_t n);
		return (n > tbtg_pkg::len_t'(tbtg_pkg::WindowDepth)) ? tbtg_pkg::WindowDepth
			: int'(n);
	endfunction

	// True when the newest len tokens of the window spell out the sequence.
	function automatic logic tail_hit(tbtg_pkg::cfg_word_t seq, int len);
		logic hit;
		int   k;
		hit = (recent_fill >= len);
		for (k = 0; k < len; k++) begin
			if (recent[k] != seq[(len - 1 - k) * 16 +: 16]) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	function automatic logic is_end_token(tbtg_pkg::token_t tok);
		logic hit;
		int   k;
		hit = 1'b0;
		for (k = 0; k < eff_len(cfg_end_cnt); k++) begin
			if (cfg_end_seq[k * 16 +: 16] == tok) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Advances the model by one decode step and returns the result it yields.
	function automatic gate_result_t gate_step(tbtg_pkg::token_t sampled);
		int           olen;
		int           clen;
		int           k;
		logic         enabled;
		gate_result_t r;
		olen = eff_len(cfg_open_len);
		clen = eff_len(cfg_close_len);
		enabled = (cfg_budget != 0) && (olen > 0) && (clen > 0);
		r = '0;
		r.code = tbtg_pkg::STOP_RUN;
		if (!halted && gate_emitted >= cfg_limit) begin
			halted = 1'b1;
			halt_reason = tbtg_pkg::STOP_LIMIT;
		end
		if (!halted) begin
			// A close length that shrank under the current position ends the forced close.
			if (enabled && forcing && force_pos >= clen) begin
				forcing = 1'b0;
				force_pos = 0;
			end
			if (enabled && forcing) begin
				r.tok = cfg_close_seq[force_pos * 16 +: 16];
				r.forced = 1'b1;
				force_pos++;
				if (force_pos >= clen) begin
					forcing = 1'b0;
					force_pos = 0;
				end
			end else begin
				r.tok = sampled;
			end
			r.valid = 1'b1;
			if (gate_emitted < 65535) begin
				gate_emitted++;
			end
			if (enabled) begin
				for (k = tbtg_pkg::WindowDepth - 1; k > 0; k--) begin
					recent[k] = recent[k - 1];
				end
				recent[0] = r.tok;
				if (recent_fill < tbtg_pkg::WindowDepth) begin
					recent_fill++;
				end
				if (tail_hit(cfg_open_seq, olen)) begin
					thinking = 1'b1;
					thought_cnt = 0;
				end else if (tail_hit(cfg_close_seq, clen)) begin
					thinking = 1'b0;
				end else if (thinking && thought_cnt < 65535) begin
					thought_cnt++;
				end
				if (thinking && !forcing && thought_cnt >= cfg_budget) begin
					forcing = 1'b1;
					force_pos = 0;
				end
			end
			if (is_end_token(r.tok)) begin
				halted = 1'b1;
				halt_reason = tbtg_pkg::STOP_END;
			end
			if (!halted && gate_emitted >= cfg_limit) begin
				halted = 1'b1;
				halt_reason = tbtg_pkg::STOP_LIMIT;
			end
		end
		r.halted = halted;
		r.code = halted ? halt_reason : tbtg_pkg::STOP_RUN;
		r.sample_next = !halted && !(enabled && forcing);
		r.thinking = thinking;
		return r;
	endfunction

	// Sends one item. Entered right after a falling edge; leaves in_valid high so that
	// back-to-back items never lower and raise it within one time step.
	task automatic send_step(input tbtg_pkg::token_t tok);
		while (gap_roll()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sampled_token <= tok;
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_results.insert(pending_results.size(), gate_step(tok));
		@(negedge clk);
	endtask

	// Drops the input valid and waits until every result has come back.
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (3) @(negedge clk);
	endtask

	// APB write followed by a read back of the same register.
	task automatic write_register(input tbtg_pkg::reg_idx_t idx,
			input tbtg_pkg::cfg_word_t value);
		tbtg_pkg::cfg_word_t stored;
		case (idx)
			tbtg_pkg::REG_THOUGHT_BUDGET: begin
				cfg_budget = tbtg_pkg::count_t'(value);
				stored = tbtg_pkg::cfg_word_t'(cfg_budget);
			end
			tbtg_pkg::REG_OPEN_LENGTH: begin
				cfg_open_len = tbtg_pkg::len_t'(value);
				stored = tbtg_pkg::cfg_word_t'(cfg_open_len);
			end
			tbtg_pkg::REG_OPEN_TOKENS: begin
				cfg_open_seq = value;
				stored = value;
			end
			tbtg_pkg::REG_CLOSE_LENGTH: begin
				cfg_close_len = tbtg_pkg::len_t'(value);
				stored = tbtg_pkg::cfg_word_t'(cfg_close_len);
			end
			tbtg_pkg::REG_CLOSE_TOKENS: begin
				cfg_close_seq = value;
				stored = value;
			end
			tbtg_pkg::REG_END_COUNT: begin
				cfg_end_cnt = tbtg_pkg::len_t'(value);
				stored = tbtg_pkg::cfg_word_t'(cfg_end_cnt);
			end
			tbtg_pkg::REG_END_TOKENS: begin
				cfg_end_seq = value;
				stored = value;
			end
			default: begin
				cfg_limit = tbtg_pkg::count_t'(value);
				stored = tbtg_pkg::cfg_word_t'(cfg_limit);
			end
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== stored) begin
			report_mismatch("register read back", prdata, stored);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Token from a small alphabet, so that random runs partly match the sequences.
	function automatic tbtg_pkg::token_t plain_token();
		tbtg_pkg::token_t tok;
		do begin
			tok = tbtg_pkg::token_t'($urandom_range(0, 7));
		end while (is_end_token(tok));
		return tok;
	endfunction

	function automatic tbtg_pkg::token_t noise_token();
		tbtg_pkg::token_t tok;
		do begin
			tok = tbtg_pkg::token_t'($urandom);
		end while (is_end_token(tok));
		return tok;
	endfunction

	function automatic tbtg_pkg::len_t random_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			return tbtg_pkg::len_t'(0);
		end else if (roll < 16) begin
			return tbtg_pkg::len_t'($urandom_range(5, 7));
		end
		return tbtg_pkg::len_t'($urandom_range(1, 4));
	endfunction

	// Sequence slots never use the top nibble pattern that the random end tokens use.
	function automatic tbtg_pkg::cfg_word_t random_sequence();
		tbtg_pkg::cfg_word_t seq;
		int                  k;
		if ($urandom_range(0, 3) == 0) begin
			seq = {$urandom, $urandom} & 64'h7FFF_7FFF_7FFF_7FFF;
		end else begin
			for (k = 0; k < tbtg_pkg::WindowDepth; k++) begin
				seq[k * 16 +: 16] = tbtg_pkg::token_t'($urandom_range(1, 6));
			end
		end
		return seq;
	endfunction

	// Reset values: forcing off, no end tokens, limit of 64. Both extremes of every bit.
	task automatic test_defaults();
		send_step(16'h0000);
		send_step(16'hFFFF);
		settle();
		write_register(tbtg_pkg::REG_TOKEN_LIMIT, tbtg_pkg::cfg_word_t'(tbtg_pkg::CountMax));
	endtask

	// Open, two thought tokens, then the three close tokens replace the sampled ones.
	task automatic test_forced_close();
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET, 2);
		write_register(tbtg_pkg::REG_OPEN_LENGTH, 2);
		write_register(tbtg_pkg::REG_OPEN_TOKENS, 64'h0000_0000_0012_0011);
		write_register(tbtg_pkg::REG_CLOSE_LENGTH, 3);
		write_register(tbtg_pkg::REG_CLOSE_TOKENS, 64'h0000_0023_0022_0021);
		write_register(tbtg_pkg::REG_END_COUNT, 0);
		send_step(16'h0011);
		send_step(16'h0012);
		send_step(16'h0100);
		send_step(16'h0101);
		repeat (3) send_step(16'hFFFF);
		send_step(16'h0200);
		settle();
	endtask

	// Lengths and the end count above the window depth behave as four.
	task automatic test_clamped_lengths();
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET, 1);
		write_register(tbtg_pkg::REG_OPEN_LENGTH, 7);
		write_register(tbtg_pkg::REG_OPEN_TOKENS, 64'h0004_0003_0002_0001);
		write_register(tbtg_pkg::REG_CLOSE_LENGTH, 5);
		write_register(tbtg_pkg::REG_CLOSE_TOKENS, 64'h0008_0007_0006_0005);
		write_register(tbtg_pkg::REG_END_COUNT, 6);
		write_register(tbtg_pkg::REG_END_TOKENS, 64'hFFF3_FFF2_FFF1_FFF0);
		send_step(16'h0001);
		send_step(16'h0002);
		send_step(16'h0003);
		send_step(16'h0004);
		send_step(16'h0009);
		repeat (4) send_step(16'hFFFF);
		settle();
	endtask

	// Open and close sequences are equal: the open match wins and restarts the count.
	task automatic test_open_priority();
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET,
			tbtg_pkg::cfg_word_t'(tbtg_pkg::CountMax));
		write_register(tbtg_pkg::REG_OPEN_LENGTH, 2);
		write_register(tbtg_pkg::REG_OPEN_TOKENS, 64'h0000_0000_0012_0011);
		write_register(tbtg_pkg::REG_CLOSE_LENGTH, 2);
		write_register(tbtg_pkg::REG_CLOSE_TOKENS, 64'h0000_0000_0012_0011);
		send_step(16'h0011);
		send_step(16'h0012);
		send_step(16'h0033);
		send_step(16'h0012);
		settle();
	endtask

	// The close length shrinks to the forcing position in the middle of a forced close,
	// then forcing is switched off by a zero budget in the middle of a thought.
	task automatic test_live_close();
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET, 1);
		write_register(tbtg_pkg::REG_OPEN_LENGTH, 1);
		write_register(tbtg_pkg::REG_OPEN_TOKENS, 64'h0000_0000_0000_0031);
		write_register(tbtg_pkg::REG_CLOSE_LENGTH, 4);
		write_register(tbtg_pkg::REG_CLOSE_TOKENS, 64'h0044_0043_0042_0041);
		send_step(16'h0031);
		send_step(16'h0050);
		send_step(16'h0060);
		settle();
		write_register(tbtg_pkg::REG_CLOSE_LENGTH, 1);
		send_step(16'h0070);
		settle();
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET, 0);
		send_step(16'h0031);
		send_step(16'h0099);
		settle();
	endtask

	// Decode traffic: mostly sequences and small-alphabet runs, some noise. While the
	// next step is forced, noise may carry an end token, which must be ignored.
	task automatic drive_thoughts(input int count);
		int sent;
		int roll;
		int run;
		int k;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 20) begin
				for (k = 0; k < eff_len(cfg_open_len); k++) begin
					send_step(cfg_open_seq[k * 16 +: 16]);
				end
				sent += eff_len(cfg_open_len);
			end else if (roll < 30) begin
				for (k = 0; k < eff_len(cfg_close_len); k++) begin
					send_step(cfg_close_seq[k * 16 +: 16]);
				end
				sent += eff_len(cfg_close_len);
			end else if (roll < 85) begin
				run = $urandom_range(1, 6);
				for (k = 0; k < run; k++) begin
					send_step(plain_token());
				end
				sent += run;
			end else begin
				run = $urandom_range(1, 3);
				for (k = 0; k < run; k++) begin
					if (cfg_budget != 0 && eff_len(cfg_open_len) > 0 && forcing
							&& force_pos < eff_len(cfg_close_len)
							&& eff_len(cfg_end_cnt) > 0) begin
						send_step(cfg_end_seq[$urandom_range(0, eff_len(cfg_end_cnt) - 1) * 16 +: 16]);
					end else begin
						send_step(noise_token());
					end
				end
				sent += run;
			end
		end
	endtask

	// Programs every register for one random phase. The first two phases pin the
	// budget to one and to its maximum; end tokens all sit in the top range of token ids.
	task automatic pick_setting(input int phase);
		tbtg_pkg::count_t budget;
		int               roll;
		roll = $urandom_range(0, 9);
		if (phase == 0) begin
			budget = 1;
		end else if (phase == 1) begin
			budget = tbtg_pkg::CountMax;
		end else if (roll == 0) begin
			budget = 0;
		end else if (roll == 1) begin
			budget = tbtg_pkg::CountMax;
		end else begin
			budget = tbtg_pkg::count_t'($urandom_range(1, 12));
		end
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET, tbtg_pkg::cfg_word_t'(budget));
		write_register(tbtg_pkg::REG_OPEN_LENGTH, tbtg_pkg::cfg_word_t'(random_length()));
		write_register(tbtg_pkg::REG_OPEN_TOKENS, random_sequence());
		write_register(tbtg_pkg::REG_CLOSE_LENGTH, tbtg_pkg::cfg_word_t'(random_length()));
		write_register(tbtg_pkg::REG_CLOSE_TOKENS, random_sequence());
		write_register(tbtg_pkg::REG_END_COUNT,
			tbtg_pkg::cfg_word_t'($urandom_range(0, 7)));
		write_register(tbtg_pkg::REG_END_TOKENS, {4'hF, 12'($urandom), 4'hF, 12'($urandom),
			4'hF, 12'($urandom), 4'hF, 12'($urandom)});
		if (phase == 0) begin
			write_register(tbtg_pkg::REG_TOKEN_LIMIT,
				tbtg_pkg::cfg_word_t'(tbtg_pkg::CountMax));
		end else begin
			write_register(tbtg_pkg::REG_TOKEN_LIMIT,
				tbtg_pkg::cfg_word_t'($urandom_range(gate_emitted + 400, 65535)));
		end
	endtask

	task automatic test_random_phases();
		int phase;
		for (phase = 0; phase < 8; phase++) begin
			pick_setting(phase);
			no_gaps = (phase == 4);
			drive_thoughts(140);
			settle();
			no_gaps = 1'b0;
		end
	endtask

	// Ends generation one of three ways, then checks that later items stay stopped.
	task automatic test_stop_conditions();
		halt_path_t path;
		int         k;
		int         pick;
		write_register(tbtg_pkg::REG_THOUGHT_BUDGET, 0);
		path = halt_path_t'($urandom_range(0, 2));
		case (path)
			HALT_BY_END_TOKEN: begin
				write_register(tbtg_pkg::REG_END_COUNT,
					tbtg_pkg::cfg_word_t'($urandom_range(1, 7)));
				write_register(tbtg_pkg::REG_END_TOKENS, {$urandom, $urandom});
				pick = $urandom_range(0, eff_len(cfg_end_cnt) - 1);
				for (k = 0; k < 3; k++) begin
					send_step(plain_token());
				end
				send_step(cfg_end_seq[pick * 16 +: 16]);
			end
			HALT_BY_LIMIT: begin
				write_register(tbtg_pkg::REG_END_COUNT, 0);
				pick = $urandom_range(1, 4);
				write_register(tbtg_pkg::REG_TOKEN_LIMIT,
					tbtg_pkg::cfg_word_t'(gate_emitted + pick));
				for (k = 0; k < pick; k++) begin
					send_step(plain_token());
				end
			end
			default: begin
				// Limit at or below the emitted count: the next step stops with no token.
				write_register(tbtg_pkg::REG_TOKEN_LIMIT,
					tbtg_pkg::cfg_word_t'($urandom_range(0, gate_emitted)));
			end
		endcase
		repeat (4) send_step(tbtg_pkg::token_t'($urandom));
		settle();
	endtask

	// Stall is changed at the falling edge, so it is stable at the sampling edge.
	always @(negedge clk) begin
		out_stall <= gap_roll();
	end

	// Each accepted result is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(out_token), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_token != want.tok) begin
					report_mismatch("out_token", 64'(out_token), 64'(want.tok));
				end
				if (token_valid != want.valid) begin
					report_mismatch("token_valid", 64'(token_valid), 64'(want.valid));
				end
				if (was_forced != want.forced) begin
					report_mismatch("was_forced", 64'(was_forced), 64'(want.forced));
				end
				if (stopped != want.halted) begin
					report_mismatch("stopped", 64'(stopped), 64'(want.halted));
				end
				if (stop_code != want.code) begin
					report_mismatch("stop_code", 64'(stop_code), 64'(want.code));
				end
				if (sample_next != want.sample_next) begin
					report_mismatch("sample_next", 64'(sample_next), 64'(want.sample_next));
				end
				if (in_thought_now != want.thinking) begin
					report_mismatch("in_thought_now", 64'(in_thought_now),
						64'(want.thinking));
				end
			end
			result_index++;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sampled_token = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_gaps = 1'b0;
		// Model state after reset.
		cfg_budget = '0;
		cfg_limit = tbtg_pkg::DefaultTokenLimit;
		cfg_open_len = '0;
		cfg_close_len = '0;
		cfg_end_cnt = '0;
		cfg_open_seq = '0;
		cfg_close_seq = '0;
		cfg_end_seq = '0;
		for (int k = 0; k < tbtg_pkg::WindowDepth; k++) begin
			recent[k] = '0;
		end
		recent_fill = 0;
		thinking = 1'b0;
		thought_cnt = 0;
		forcing = 1'b0;
		force_pos = 0;
		gate_emitted = 0;
		halted = 1'b0;
		halt_reason = tbtg_pkg::STOP_RUN;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_defaults();
		test_forced_close();
		test_clamped_lengths();
		test_open_priority();
		test_live_close();
		test_random_phases();
		test_stop_conditions();

		if (pending_results.size() != 0) begin
			report_mismatch("results never arrived", 64'(pending_results.size()), 64'd0);
		end
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
